>>> design/ksu_pkg.sv
package ksu_pkg;

  // default operand width for both n and p
  localparam int unsigned OPERAND_WIDTH_DEF = 31;

  // symbol field, two's complement
  localparam int unsigned SYMBOL_W = 2;
  localparam logic [SYMBOL_W-1:0] SYM_ZERO = 2'b00;
  localparam logic [SYMBOL_W-1:0] SYM_POS  = 2'b01;
  localparam logic [SYMBOL_W-1:0] SYM_NEG  = 2'b11;

  // low three bits of a value; true when (2/v) is -1 (residue not 1 or 7)
  function automatic logic mod8_neg(input logic [2:0] res);
    mod8_neg = !((res == 3'd1) || (res == 3'd7));
  endfunction

  // signed symbol from the running sign bit
  function automatic logic [SYMBOL_W-1:0] sign_sym(input logic neg);
    sign_sym = neg ? SYM_NEG : SYM_POS;
  endfunction

endpackage

>>> design/ksu_mod_unit.sv
module ksu_mod_unit import ksu_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] remainder
);

  localparam int unsigned CW = $clog2(OPERAND_WIDTH + 1);

  logic [OPERAND_WIDTH-1:0] quo_r, quo_nxt;
  logic [OPERAND_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [OPERAND_WIDTH-1:0] rem_r, rem_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH:0]   diff;

  // restoring remainder step: one dividend bit per cycle, MSB first
  assign trial = {rem_r, quo_r[OPERAND_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[OPERAND_WIDTH-2:0], 1'b0};
      rem_nxt = diff[OPERAND_WIDTH] ? trial[OPERAND_WIDTH-1:0] : diff[OPERAND_WIDTH-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(OPERAND_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> design/kronecker_symbol_unit.sv
// Channel | Dir | Ports                        | Beat contents
// in_     | in  | in_tvalid/in_tready/in_tdata | top_value n, bottom_value p
// out_    | out | out_tvalid/out_tready/out_tdata | symbol (-1, 0, 1)
//
// One item at a time. Each reduction step is one pass through the check
// state plus one remainder (max(n,p) mod min(n,p)) on the shared bit-serial
// unit. Steps count halvings and Euclid reductions, at most about
// 2*OPERAND_WIDTH + 1. Trivial items (n or p is 0, 1 or equal) skip the
// remainder unit and go from the check state straight to done.
// Reset (rst_n, synchronous) empties the output register and returns to idle.
// in_tready is high only while idle; a held result does not block the next beat.
module kronecker_symbol_unit import ksu_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [OPERAND_WIDTH-1:0] top_value, [2*OPERAND_WIDTH-1:OPERAND_WIDTH] bottom_value,
  // zero padded to bytes
  input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [1:0] symbol, [7:2] zero
  output logic [7:0]              out_tdata
);

  localparam int unsigned W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [W-1:0]        n_r, n_nxt;
  logic [W-1:0]        p_r, p_nxt;
  logic                neg_r, neg_nxt;      // running sign of the product
  logic [SYMBOL_W-1:0] res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYMBOL_W-1:0] out_sym_r, out_sym_nxt;

  logic         n_lt_p;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_rem;
  logic [W-1:0] div_a;
  logic [W-1:0] div_b;

  assign n_lt_p = n_r < p_r;
  assign div_a  = n_lt_p ? p_r : n_r;
  assign div_b  = n_lt_p ? n_r : p_r;

  ksu_mod_unit #(.OPERAND_WIDTH(W)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt     = in_tdata[W-1:0];
          p_nxt     = in_tdata[2*W-1:W];
          neg_nxt   = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((n_r == W'(1)) || (p_r == W'(1))) begin
          res_nxt   = sign_sym(neg_r);
          state_nxt = S_DONE;
        end else if ((p_r == '0) || (n_r == '0) || (n_r == p_r)) begin
          res_nxt   = SYM_ZERO;
          state_nxt = S_DONE;
        end else begin
          // larger mod smaller covers both divisibility tests and p mod n
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CHECK;
          if (div_rem == '0) begin
            res_nxt   = SYM_ZERO;
            state_nxt = S_DONE;
          end else if (n_r == W'(2)) begin
            res_nxt   = sign_sym(neg_r ^ mod8_neg(p_r[2:0]));
            state_nxt = S_DONE;
          end else if (p_r == W'(2)) begin
            res_nxt   = sign_sym(neg_r ^ mod8_neg(n_r[2:0]));
            state_nxt = S_DONE;
          end else if (p_r[0]) begin
            if (n_r[0]) begin
              // reciprocity: (n/p) -> (p mod n / n), or -> (p / n) when n > p
              neg_nxt = neg_r ^ (n_r[1] & p_r[1]);
              n_nxt   = n_lt_p ? div_rem : p_r;
              p_nxt   = n_r;
            end else begin
              neg_nxt = neg_r ^ mod8_neg(p_r[2:0]);
              n_nxt   = {1'b0, n_r[W-1:1]};
            end
          end else if (!n_r[0]) begin
            res_nxt   = SYM_ZERO;
            state_nxt = S_DONE;
          end else begin
            neg_nxt = neg_r ^ mod8_neg(n_r[2:0]);
            p_nxt   = {1'b0, p_r[W-1:1]};
          end
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    neg_r     <= neg_nxt;
    res_r     <= res_nxt;
    out_sym_r <= out_sym_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - SYMBOL_W){1'b0}}, out_sym_r};

endmodule
